@@ hw/rtl/dtc_pkg.sv @@
// package for the delta trend classifier: widths, defaults, codes and
// the command/status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

  localparam int DELTA_BITS_DEF     = 24;
  localparam int RATE_FRAC_BITS_DEF = 8;

  localparam int TIME_W     = 32;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CODE_W     = 2;
  localparam int RATE_OUT_W = 19;

  // ms to s scale factor and its width
  localparam int SCALE_MS = 1000;
  localparam int SCALE_W  = 10;

  // smoothing: rate = (179*rate + 77*inst) >> 8
  localparam int SMOOTH_OLD   = 179;
  localparam int SMOOTH_NEW   = 77;
  localparam int SMOOTH_SHIFT = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TREND_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CLAMP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL    = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] TREND_THRESHOLD_RST = 10'd4;
  localparam logic [CFG_W-1:0] RATE_CLAMP_RST      = 10'd100;
  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST    = 10'd20;

  typedef enum logic [CODE_W-1:0] {
    CODE_NONE   = 2'd0,
    CODE_STEADY = 2'd1,
    CODE_GAIN   = 2'd2,
    CODE_LOSS   = 2'd3
  } trend_t;

  typedef struct packed {
    logic load;      // capture input word
    logic diff;      // difference, elapsed time, interval test
    logic chk;       // clamp test, divider load
    logic div_step;  // one quotient bit
    logic upd;       // state and smoothed rate update
    logic out_load;  // load result register
  } dtc_cmd_t;

  typedef struct packed {
    logic div_done;
  } dtc_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/dtc_in_if.sv @@
// input channel: valid/ready handshake with one timed delta sample
// depends on dtc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dtc_in_if #(
  parameter int DELTA_BITS = dtc_pkg::DELTA_BITS_DEF
);
  import dtc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         sample_valid;
  logic signed [DELTA_BITS-1:0] delta_value;
  logic [TIME_W-1:0]            time_ms;

  modport source (output valid, output sample_valid, output delta_value, output time_ms,
                  input ready);
  modport sink   (input valid, input sample_valid, input delta_value, input time_ms,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dtc_out_if.sv @@
// result channel: valid/ready handshake with trend code and smoothed rate
// depends on dtc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dtc_out_if;
  import dtc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CODE_W-1:0]            trend_code;
  logic signed [RATE_OUT_W-1:0] smoothed_rate;

  modport source (output valid, output trend_code, output smoothed_rate, input ready);
  modport sink   (input valid, input trend_code, input smoothed_rate, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dtc_cfg_if.sv @@
// configuration write channel: valid/ready with register index and data
// depends on dtc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dtc_cfg_if;
  import dtc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dtc_div.sv @@
// restoring serial divider, one quotient bit per step
// quotient is known to fit QUO_W bits when the result is used; depends on dtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtc_div #(
  parameter int NUM_W = 43,
  parameter int QUO_W = 18
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic                      step,
  input  logic [NUM_W-1:0]          dividend,
  input  logic [dtc_pkg::TIME_W-1:0] divisor,
  output logic [QUO_W-1:0]          quotient,
  output logic                      done
);
  import dtc_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] dsr_r;
  logic [QUO_W-1:0]  lo_r;
  logic [QUO_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [TIME_W:0]   trial;
  logic              ge;
  logic [TIME_W-1:0] rem_nxt;

  assign trial   = {rem_r, lo_r[QUO_W-1]};
  assign ge      = trial >= {1'b0, dsr_r};
  // partial remainder ends below the divisor when the quotient fits QUO_W bits
  assign rem_nxt = ge ? TIME_W'(trial - {1'b0, dsr_r}) : TIME_W'(trial);
  assign done    = cnt_r == CNT_W'(QUO_W);
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= '0;
    end else if (step && !done) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= TIME_W'(dividend[NUM_W-1:QUO_W]);
      lo_r  <= dividend[QUO_W-1:0];
      dsr_r <= divisor;
      quo_r <= '0;
    end else if (step && !done) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dtc_datapath.sv @@
// datapath: config registers, sample history, clamp test, rate divider,
// smoothing update, trend compare and result register; depends on dtc_pkg, dtc_div
`timescale 1ns / 1ps
`default_nettype none

module dtc_datapath #(
  parameter int DELTA_BITS     = dtc_pkg::DELTA_BITS_DEF,
  parameter int RATE_FRAC_BITS = dtc_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dtc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [dtc_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_sample_valid,
  input  logic signed [DELTA_BITS-1:0]     in_delta,
  input  logic [dtc_pkg::TIME_W-1:0]       in_time,
  input  dtc_pkg::dtc_cmd_t                cmd,
  output dtc_pkg::dtc_stat_t               stat,
  output logic [dtc_pkg::CODE_W-1:0]       out_code,
  output logic signed [dtc_pkg::RATE_OUT_W-1:0] out_rate
);
  import dtc_pkg::*;

  localparam int QUO_W  = CFG_W + RATE_FRAC_BITS;
  localparam int ACC_W  = QUO_W + 2;
  localparam int MAG_W  = DELTA_BITS + 1;
  localparam int PROD_W = MAG_W + SCALE_W;
  localparam int NUM_W  = PROD_W + RATE_FRAC_BITS;
  localparam int LIM_W  = CFG_W + TIME_W;
  localparam int CMP_W  = (PROD_W > LIM_W) ? PROD_W : LIM_W;
  localparam int SUM_W  = ACC_W + SMOOTH_SHIFT + 2;
  localparam int THR_W  = CFG_W + RATE_FRAC_BITS;
  localparam int EXT_W  = (ACC_W > RATE_OUT_W) ? ACC_W : RATE_OUT_W;

  // configuration
  logic [CFG_W-1:0] thr_cfg_r, clamp_cfg_r, min_cfg_r;

  // captured word
  logic                         sv_r;
  logic signed [DELTA_BITS-1:0] delta_r;
  logic [TIME_W-1:0]            time_r;

  // history and smoothed rate
  logic                         have_prev_r;
  logic signed [DELTA_BITS-1:0] prev_delta_r;
  logic [TIME_W-1:0]            prev_time_r;
  logic signed [ACC_W-1:0]      acc_r;

  // per-word intermediates
  logic              first_r, changed_r, late_r, neg_r, use_r;
  logic [MAG_W-1:0]  mag_r;
  logic [TIME_W-1:0] elapsed_r;

  logic [CODE_W-1:0]            out_code_r;
  logic signed [RATE_OUT_W-1:0] out_rate_r;

  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag;
  logic [TIME_W-1:0]       elapsed;
  logic [PROD_W-1:0]       prod;
  logic [LIM_W-1:0]        lim;
  logic                    keep;
  logic [NUM_W-1:0]        num;
  logic [QUO_W-1:0]        quo;
  logic signed [ACC_W-1:0] inst;
  logic signed [SUM_W-1:0] acc_x, inst_x, sum;
  logic signed [ACC_W-1:0] acc_nxt;
  logic [THR_W-1:0]        thr;
  logic signed [ACC_W-1:0] thr_s;
  logic signed [EXT_W-1:0] rate_ext;
  trend_t                  code_nxt;

  assign diff    = MAG_W'(delta_r) - MAG_W'(prev_delta_r);
  assign mag     = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign elapsed = time_r - prev_time_r;

  // exact clamp test: |diff|*1000 < clamp*elapsed
  assign prod = PROD_W'(mag_r) * PROD_W'(SCALE_MS);
  assign lim  = LIM_W'(clamp_cfg_r) * LIM_W'(elapsed_r);
  assign keep = CMP_W'(prod) < CMP_W'(lim);
  assign num  = NUM_W'(prod) << RATE_FRAC_BITS;

  dtc_div #(
    .NUM_W (NUM_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.chk),
    .step     (cmd.div_step),
    .dividend (num),
    .divisor  (elapsed_r),
    .quotient (quo),
    .done     (stat.div_done)
  );

  // quotient truncated toward zero, then signed
  assign inst    = neg_r ? -ACC_W'(quo) : ACC_W'(quo);
  assign acc_x   = SUM_W'(acc_r);
  assign inst_x  = SUM_W'(inst);
  assign sum     = acc_x * SUM_W'(SMOOTH_OLD) + inst_x * SUM_W'(SMOOTH_NEW);
  assign acc_nxt = ACC_W'(sum >>> SMOOTH_SHIFT);

  assign thr      = THR_W'(thr_cfg_r) << RATE_FRAC_BITS;
  assign thr_s    = $signed(ACC_W'(thr));
  assign rate_ext = EXT_W'(acc_r);

  always_comb begin
    if (!sv_r) begin
      code_nxt = CODE_NONE;
    end else if (first_r) begin
      code_nxt = CODE_STEADY;
    end else if (acc_r <= -thr_s) begin
      code_nxt = CODE_GAIN;
    end else if (acc_r >= thr_s) begin
      code_nxt = CODE_LOSS;
    end else begin
      code_nxt = CODE_STEADY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_cfg_r   <= TREND_THRESHOLD_RST;
      clamp_cfg_r <= RATE_CLAMP_RST;
      min_cfg_r   <= MIN_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TREND_THRESHOLD: thr_cfg_r   <= cfg_wdata;
        REG_RATE_CLAMP:      clamp_cfg_r <= cfg_wdata;
        REG_MIN_INTERVAL:    min_cfg_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      acc_r       <= '0;
    end else if (cmd.upd) begin
      if (!sv_r) begin
        have_prev_r <= 1'b0;
        acc_r       <= '0;
      end else if (first_r) begin
        have_prev_r <= 1'b1;
        acc_r       <= '0;
      end else if (use_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_delta_r <= '0;
      prev_time_r  <= '0;
    end else if (cmd.upd && sv_r && (first_r || changed_r)) begin
      prev_delta_r <= delta_r;
      prev_time_r  <= time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sv_r    <= in_sample_valid;
      delta_r <= in_delta;
      time_r  <= in_time;
    end
    if (cmd.diff) begin
      first_r   <= !have_prev_r;
      changed_r <= delta_r != prev_delta_r;
      neg_r     <= diff[MAG_W-1];
      mag_r     <= mag;
      elapsed_r <= elapsed;
      late_r    <= elapsed > TIME_W'(min_cfg_r);
    end
    if (cmd.chk) begin
      use_r <= sv_r && !first_r && changed_r && late_r && keep;
    end
    if (cmd.out_load) begin
      out_code_r <= code_nxt;
      out_rate_r <= rate_ext[RATE_OUT_W-1:0];
    end
  end

  assign out_code = out_code_r;
  assign out_rate = out_rate_r;

endmodule

`default_nettype wire

@@ hw/rtl/dtc_ctrl.sv @@
// controller: sequences capture, difference, clamp check, divide, update
// and result load, owns the channel handshakes; depends on dtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  dtc_pkg::dtc_stat_t stat,
  output dtc_pkg::dtc_cmd_t  cmd
);
  import dtc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_CHK,
    S_DIV,
    S_UPD,
    S_FIN
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   out_free;

  // result register empty or emptied this cycle
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd      = '0;
    cmd.load = in_valid && in_ready_r;
    case (state_r)
      S_DIFF:  cmd.diff     = 1'b1;
      S_CHK:   cmd.chk      = 1'b1;
      S_DIV:   cmd.div_step = !stat.div_done;
      S_UPD:   cmd.upd      = 1'b1;
      S_FIN:   cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_FIN the result register is reloaded below instead
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            in_ready_r <= 1'b0;
            state_r    <= S_DIFF;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        S_DIFF: state_r <= S_CHK;
        S_CHK:  state_r <= S_DIV;
        S_DIV: begin
          if (stat.div_done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD:  state_r <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            in_ready_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hw/rtl/delta_trend_classifier_unit.sv @@
// delta trend classifier top: controller plus datapath with serial divider
// each accepted word steps through S_DIFF, S_CHK, S_DIV, S_UPD and S_FIN
// no new word is taken until S_FIN loads the result; S_DIV runs the one-bit-per-cycle
//   divider for 10+RATE_FRAC_BITS quotient bits
// reset: synchronous active-low; registers return to defaults, history and rate cleared
// depends on dtc_pkg, dtc_in_if, dtc_out_if, dtc_cfg_if, dtc_div, dtc_datapath, dtc_ctrl
`timescale 1ns / 1ps
`default_nettype none

module delta_trend_classifier_unit #(
  parameter int DELTA_BITS     = dtc_pkg::DELTA_BITS_DEF,
  parameter int RATE_FRAC_BITS = dtc_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dtc_in_if.sink    in_ch,
  dtc_out_if.source out_ch,
  dtc_cfg_if.sink   cfg_ch
);
  import dtc_pkg::*;

  dtc_cmd_t  cmd;
  dtc_stat_t stat;

  // config writes are taken at any time
  assign cfg_ch.ready = 1'b1;

  dtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtc_datapath #(
    .DELTA_BITS     (DELTA_BITS),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_ch.valid),
    .cfg_idx         (cfg_ch.reg_index),
    .cfg_wdata       (cfg_ch.wdata),
    .in_sample_valid (in_ch.sample_valid),
    .in_delta        (in_ch.delta_value),
    .in_time         (in_ch.time_ms),
    .cmd             (cmd),
    .stat            (stat),
    .out_code        (out_ch.trend_code),
    .out_rate        (out_ch.smoothed_rate)
  );

endmodule

`default_nettype wire
